FILE: hdl/urb_pkg.sv
// Types, constants and interrupt helper functions shared by the UART register block.
package urb_pkg;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [4:0] SLOT_RBR = 5'd0;
   localparam logic [4:0] SLOT_IER = 5'd1;
   localparam logic [4:0] SLOT_IIR = 5'd2;
   localparam logic [4:0] SLOT_LCR = 5'd3;
   localparam logic [4:0] SLOT_MCR = 5'd4;
   localparam logic [4:0] SLOT_LSR = 5'd5;
   localparam logic [4:0] SLOT_MSR = 5'd6;
   localparam logic [4:0] SLOT_SCR = 5'd7;

   localparam logic [1:0] SRC_MOD = 2'd0;
   localparam logic [1:0] SRC_THR = 2'd1;
   localparam logic [1:0] SRC_RDA = 2'd2;
   localparam logic [1:0] SRC_RLS = 2'd3;

   localparam logic [7:0] LCR_RESET   = 8'h03;
   localparam logic [7:0] MCR_RESET   = 8'h08;
   localparam logic [7:0] MSR_VALUE   = 8'h10;
   localparam logic [3:0] IER_MASK    = 4'hF;

   typedef struct packed {
      logic [1:0] id;
      logic       none;
   } ident_type;

   localparam ident_type IDENT_NONE = '{id: 2'd0, none: 1'b1};

   typedef struct packed {
      op_type     op;
      logic [7:0] addr;
      logic [7:0] wdata;
      logic       tx_taken;
      logic       rx_valid;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       bus_error;
      logic       irq_pending;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_taken;
   } rsp_type;

   function automatic logic src_enabled(logic [1:0] id, logic [3:0] ie);
      logic en;
      case (id)
         SRC_MOD: en = ie[3];
         SRC_THR: en = ie[1];
         SRC_RDA: en = ie[0];
         default: en = ie[2];
      endcase
      return en;
   endfunction

   // The pending id only ever moves up to the higher of the new and current ids.
   function automatic ident_type raise_src(ident_type cur, logic [1:0] id, logic [3:0] ie);
      logic [1:0] cur_id;
      logic [1:0] nxt;
      ident_type  res;
      cur_id = cur.none ? 2'd0 : cur.id;
      nxt    = (id >= cur_id) ? id : cur_id;
      res    = cur;
      if (src_enabled(nxt, ie)) begin
         res.none = 1'b0;
         res.id   = nxt;
      end
      return res;
   endfunction

   function automatic ident_type clear_src(ident_type cur, logic [1:0] id);
      ident_type res;
      res = cur;
      if (!cur.none && (cur.id == id)) begin
         res = IDENT_NONE;
      end
      return res;
   endfunction

endpackage

FILE: hdl/urb_core.sv
// Register file of the UART block: architectural state and the update for one item.
module urb_core
   import urb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   logic [7:0] rbr_ff, rbr_in;
   logic [7:0] thr_ff, thr_in;
   logic [3:0] ier_ff, ier_in;
   ident_type  iir_ff, iir_in;
   logic       lcr_set_ff, lcr_set_in;
   logic       mcr_set_ff, mcr_set_in;
   logic       dr_ff, dr_in;
   logic       the_ff, the_in;
   logic [7:0] scr_ff, scr_in;

   logic       wr;
   logic [4:0] slot;

   assign wr   = (item.op == OP_WRITE);
   assign slot = item.addr[6:2];

   always_comb begin
      rbr_in     = rbr_ff;
      thr_in     = thr_ff;
      ier_in     = ier_ff;
      iir_in     = iir_ff;
      lcr_set_in = lcr_set_ff;
      mcr_set_in = mcr_set_ff;
      dr_in      = dr_ff;
      the_in     = the_ff;
      scr_in     = scr_ff;
      result     = '0;
      case (item.op)
         OP_READ, OP_WRITE: begin
            if (item.addr[7]) begin
               result.bus_error = 1'b1;
            end else begin
               case (slot)
                  SLOT_RBR: begin
                     if (!wr) begin
                        iir_in       = raise_src(clear_src(iir_ff, SRC_RDA), SRC_RLS, ier_ff);
                        result.rdata = rbr_ff;
                        dr_in        = 1'b0;
                     end else begin
                        iir_in = raise_src(clear_src(iir_ff, SRC_THR), SRC_RLS, ier_ff);
                        thr_in = item.wdata;
                        the_in = 1'b0;
                     end
                  end
                  SLOT_IER: begin
                     if (!wr) result.rdata = {4'b0000, ier_ff};
                     else ier_in = item.wdata[3:0] & IER_MASK;
                  end
                  SLOT_IIR: begin
                     if (!wr) begin
                        result.rdata = {5'b00000, iir_ff.id, iir_ff.none};
                        iir_in       = clear_src(iir_ff, SRC_THR);
                     end
                  end
                  SLOT_LCR: begin
                     if (!wr) result.rdata = lcr_set_ff ? LCR_RESET : 8'h00;
                     else lcr_set_in = 1'b0;
                  end
                  SLOT_MCR: begin
                     if (!wr) result.rdata = mcr_set_ff ? MCR_RESET : 8'h00;
                     else mcr_set_in = 1'b0;
                  end
                  SLOT_LSR: begin
                     if (!wr) begin
                        iir_in       = clear_src(iir_ff, SRC_RLS);
                        result.rdata = {1'b0, 1'b1, the_ff, 4'b0000, dr_ff};
                     end
                  end
                  SLOT_MSR: begin
                     if (!wr) begin
                        iir_in       = clear_src(iir_ff, SRC_MOD);
                        result.rdata = MSR_VALUE;
                     end
                  end
                  SLOT_SCR: begin
                     if (!wr) result.rdata = scr_ff;
                     else scr_in = item.wdata;
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_TICK: begin
            if (!the_ff) begin
               result.tx_valid = 1'b1;
               result.tx_byte  = thr_ff;
               if (item.tx_taken) begin
                  the_in = 1'b1;
                  iir_in = raise_src(raise_src(iir_ff, SRC_THR, ier_ff), SRC_RLS, ier_ff);
               end
            end
            if (!dr_ff && item.rx_valid) begin
               rbr_in          = item.rx_byte;
               dr_in           = 1'b1;
               iir_in          = raise_src(raise_src(iir_in, SRC_RDA, ier_ff), SRC_RLS, ier_ff);
               result.rx_taken = 1'b1;
            end
         end
         default: begin
         end
      endcase
      result.irq_pending = !iir_in.none;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rbr_ff     <= 8'h00;
         thr_ff     <= 8'h00;
         ier_ff     <= 4'h0;
         iir_ff     <= IDENT_NONE;
         lcr_set_ff <= 1'b1;
         mcr_set_ff <= 1'b1;
         dr_ff      <= 1'b0;
         the_ff     <= 1'b1;
         scr_ff     <= 8'h00;
      end else if (fire) begin
         rbr_ff     <= rbr_in;
         thr_ff     <= thr_in;
         ier_ff     <= ier_in;
         iir_ff     <= iir_in;
         lcr_set_ff <= lcr_set_in;
         mcr_set_ff <= mcr_set_in;
         dr_ff      <= dr_in;
         the_ff     <= the_in;
         scr_ff     <= scr_in;
      end
   end

endmodule

FILE: hdl/uart_8250_register_block.sv
// Top level of the 8250-style UART register block with input and result registers.
//
// Usage: each request item is a bus read, a bus write or a tick. A bus access
// addresses slot addr[7:2]; slots 0 to 7 are the UART registers, 8 to 31 read
// as zero and ignore writes, and 32 and above return bus_error. A tick presents
// the transmit holding byte and offers a received byte through the handshake
// flags. Every request gives exactly one response item.
// Flow: an accepted item is held in the input register, processed by the core
// and its response is registered in the result register that drives the
// response ports. One item is accepted every cycle unless rsp_stall holds a
// response; the register update and the response are formed in shallow logic
// between the input register and the result register.
// Reset: a synchronous reset empties both registers and returns every UART
// register to its power-on value; no item is pending afterwards.
// Stall: while rsp_stall holds a response, the item behind it waits in the
// input register and req_stall rises only once that register is also full.
module uart_8250_register_block
   import urb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_addr,
   input  logic [7:0] req_wdata,
   input  logic       req_tx_taken,
   input  logic       req_rx_valid,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_rdata,
   output logic       rsp_bus_error,
   output logic       rsp_irq_pending,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_rx_taken
);

   logic    in_valid_ff;
   req_type in_item_ff;
   logic    out_valid_ff;
   rsp_type out_item_ff;
   rsp_type result;
   logic    fire;
   logic    accept;

   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   urb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.op       <= op_type'(req_op);
         in_item_ff.addr     <= req_addr;
         in_item_ff.wdata    <= req_wdata;
         in_item_ff.tx_taken <= req_tx_taken;
         in_item_ff.rx_valid <= req_rx_valid;
         in_item_ff.rx_byte  <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_rdata       = out_item_ff.rdata;
   assign rsp_bus_error   = out_item_ff.bus_error;
   assign rsp_irq_pending = out_item_ff.irq_pending;
   assign rsp_tx_valid    = out_item_ff.tx_valid;
   assign rsp_tx_byte     = out_item_ff.tx_byte;
   assign rsp_rx_taken    = out_item_ff.rx_taken;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with an empty input register");

   a_item_moves_out: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("item did not reach the result register");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_error |-> (rsp_rdata == 8'h00) && !rsp_tx_valid && !rsp_rx_taken)
      else $error("bus error response carries data");

   a_tx_byte_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> (rsp_tx_byte == 8'h00))
      else $error("transmit byte shown without transmit valid");

endmodule

FILE: verif/uart_8250_register_block_chk.sv
// Checker that predicts the UART register block's responses and compares them item by item.
`timescale 1ns / 100ps

module uart_8250_register_block_chk
   import urb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_addr,
   input  logic [7:0] req_wdata,
   input  logic       req_tx_taken,
   input  logic       req_rx_valid,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_rdata,
   input  logic       rsp_bus_error,
   input  logic       rsp_irq_pending,
   input  logic       rsp_tx_valid,
   input  logic [7:0] rsp_tx_byte,
   input  logic       rsp_rx_taken,
   output int         errors,
   output int         outstanding
);

   localparam int LSR_DR  = 0;
   localparam int LSR_THE = 5;
   localparam int LSR_TSE = 6;

   logic [7:0] rx_buf;
   logic [7:0] tx_hold;
   logic [3:0] ier;
   ident_type  iir;
   logic [7:0] lcr;
   logic [7:0] mcr;
   logic [7:0] lsr;
   logic [7:0] msr;
   logic [7:0] scr;
   rsp_type    response_q[$];

   initial begin
      errors      = 0;
      outstanding = 0;
   end

   function automatic logic irq_enabled(logic [1:0] id);
      logic en;
      case (id)
         SRC_RLS: en = ier[2];
         SRC_RDA: en = ier[0];
         SRC_THR: en = ier[1];
         default: en = ier[3];
      endcase
      return en;
   endfunction

   task automatic raise_irq(input logic [1:0] id);
      logic [1:0] held;
      logic [1:0] top;
      held = iir.none ? SRC_MOD : iir.id;
      top  = (id >= held) ? id : held;
      if (irq_enabled(top)) begin
         iir.none = 1'b0;
         iir.id   = top;
      end
   endtask

   task automatic drop_irq(input logic [1:0] id);
      if (!iir.none && iir.id == id) begin
         iir = IDENT_NONE;
      end
   endtask

   task automatic predict_response(output rsp_type r);
      logic [5:0] slot;
      logic       wr;
      slot = req_addr[7:2];
      r    = '0;
      case (op_type'(req_op))
         OP_READ, OP_WRITE: begin
            wr = (op_type'(req_op) == OP_WRITE);
            if (slot >= 6'd32) begin
               r.bus_error = 1'b1;
            end else begin
               case (slot)
                  6'(SLOT_RBR): begin
                     if (!wr) begin
                        drop_irq(SRC_RDA);
                        raise_irq(SRC_RLS);
                        r.rdata     = rx_buf;
                        lsr[LSR_DR] = 1'b0;
                     end else begin
                        drop_irq(SRC_THR);
                        raise_irq(SRC_RLS);
                        tx_hold      = req_wdata;
                        lsr[LSR_THE] = 1'b0;
                     end
                  end
                  6'(SLOT_IER): begin
                     if (!wr) r.rdata = {4'h0, ier};
                     else ier = req_wdata[3:0];
                  end
                  6'(SLOT_IIR): begin
                     if (!wr) begin
                        r.rdata = {5'h00, iir};
                        drop_irq(SRC_THR);
                     end
                  end
                  6'(SLOT_LCR): begin
                     if (!wr) r.rdata = lcr;
                     else lcr = 8'h00;
                  end
                  6'(SLOT_MCR): begin
                     if (!wr) r.rdata = mcr;
                     else mcr = 8'h00;
                  end
                  6'(SLOT_LSR): begin
                     if (!wr) begin
                        drop_irq(SRC_RLS);
                        r.rdata = lsr;
                     end
                  end
                  6'(SLOT_MSR): begin
                     if (!wr) begin
                        drop_irq(SRC_MOD);
                        r.rdata = msr;
                     end
                  end
                  6'(SLOT_SCR): begin
                     if (!wr) r.rdata = scr;
                     else scr = req_wdata;
                  end
                  default: ;
               endcase
            end
         end
         OP_TICK: begin
            if (!lsr[LSR_THE]) begin
               r.tx_valid = 1'b1;
               r.tx_byte  = tx_hold;
               if (req_tx_taken) begin
                  lsr[LSR_THE] = 1'b1;
                  lsr[LSR_TSE] = 1'b1;
                  raise_irq(SRC_THR);
                  raise_irq(SRC_RLS);
               end
            end
            if (!lsr[LSR_DR] && req_rx_valid) begin
               rx_buf      = req_rx_byte;
               lsr[LSR_DR] = 1'b1;
               raise_irq(SRC_RDA);
               raise_irq(SRC_RLS);
               r.rx_taken  = 1'b1;
            end
         end
         default: ;
      endcase
      r.irq_pending = !iir.none;
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type next;
      if (reset) begin
         rx_buf  = 8'h00;
         tx_hold = 8'h00;
         ier     = 4'h0;
         iir     = IDENT_NONE;
         lcr     = LCR_RESET;
         mcr     = MCR_RESET;
         lsr     = 8'h00;
         lsr[LSR_THE] = 1'b1;
         lsr[LSR_TSE] = 1'b1;
         msr     = MSR_VALUE;
         scr     = 8'h00;
         response_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (response_q.size() == 0) begin
               $error("Response item arrived with none expected.");
               errors++;
            end else begin
               want = response_q.pop_front();
               check_field("rdata", want.rdata, rsp_rdata);
               check_field("bus_error", want.bus_error, rsp_bus_error);
               check_field("irq_pending", want.irq_pending, rsp_irq_pending);
               check_field("tx_valid", want.tx_valid, rsp_tx_valid);
               check_field("tx_byte", want.tx_byte, rsp_tx_byte);
               check_field("rx_taken", want.rx_taken, rsp_rx_taken);
            end
         end
         if (req_valid && !req_stall) begin
            predict_response(next);
            response_q.push_back(next);
         end
      end
      outstanding = response_q.size();
   end

endmodule

FILE: verif/uart_8250_register_block_tb.sv
// Testbench top that drives bus accesses, ticks and no-op items into the UART register block.
`timescale 1ns / 100ps

module uart_8250_register_block_tb
   import urb_pkg::*;
();

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic [1:0] req_op       = 2'd0;
   logic [7:0] req_addr     = 8'h00;
   logic [7:0] req_wdata    = 8'h00;
   logic       req_tx_taken = 1'b0;
   logic       req_rx_valid = 1'b0;
   logic [7:0] req_rx_byte  = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall    = 1'b0;
   logic [7:0] rsp_rdata;
   logic       rsp_bus_error;
   logic       rsp_irq_pending;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_rx_taken;

   int   errors;
   int   outstanding;
   logic stall_en   = 1'b0;
   logic gap_en     = 1'b0;
   int   stall_left = 0;

   uart_8250_register_block u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_addr        (req_addr),
      .req_wdata       (req_wdata),
      .req_tx_taken    (req_tx_taken),
      .req_rx_valid    (req_rx_valid),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rdata       (rsp_rdata),
      .rsp_bus_error   (rsp_bus_error),
      .rsp_irq_pending (rsp_irq_pending),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_rx_taken    (rsp_rx_taken)
   );

   uart_8250_register_block_chk u_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_addr        (req_addr),
      .req_wdata       (req_wdata),
      .req_tx_taken    (req_tx_taken),
      .req_rx_valid    (req_rx_valid),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rdata       (rsp_rdata),
      .rsp_bus_error   (rsp_bus_error),
      .rsp_irq_pending (rsp_irq_pending),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_rx_taken    (rsp_rx_taken),
      .errors          (errors),
      .outstanding     (outstanding)
   );

   always #5 clock = ~clock;

   function automatic int idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin
      if (!stall_en) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= idle_len() - 1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_item(input op_type op, input logic [7:0] addr,
                            input logic [7:0] wdata, input logic tx_taken,
                            input logic rx_valid, input logic [7:0] rx_byte);
      logic stalled;
      req_valid    <= 1'b1;
      req_op       <= op;
      req_addr     <= addr;
      req_wdata    <= wdata;
      req_tx_taken <= tx_taken;
      req_rx_valid <= rx_valid;
      req_rx_byte  <= rx_byte;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      if (gap_en && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (idle_len()) @(posedge clock);
      end
   endtask

   task automatic bus_access(input op_type op, input logic [7:0] addr,
                             input logic [7:0] wdata);
      send_item(op, addr, wdata, 1'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic tick(input logic tx_taken, input logic rx_valid,
                       input logic [7:0] rx_byte);
      send_item(OP_TICK, 8'($urandom), 8'($urandom), tx_taken, rx_valid, rx_byte);
   endtask

   function automatic logic [7:0] random_addr();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 16) return 8'($urandom_range(0, 31));
      if (pick < 18) return 8'($urandom_range(32, 127));
      return 8'($urandom_range(128, 255));
   endfunction

   task automatic send_random();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         bus_access(OP_READ, random_addr(), 8'($urandom));
      end else if (pick < 68) begin
         bus_access(OP_WRITE, random_addr(), 8'($urandom));
      end else if (pick < 97) begin
         tick(1'($urandom), $urandom_range(0, 3) != 0, 8'($urandom));
      end else begin
         send_item(OP_NONE, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                   8'($urandom));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int s = 0; s < 8; s++) begin
         bus_access(OP_READ, 8'(s * 4 + s % 4), 8'h00);
      end
      bus_access(OP_WRITE, {1'b0, SLOT_IER, 2'b00}, 8'hFF);
      bus_access(OP_WRITE, {1'b0, SLOT_SCR, 2'b11}, 8'hFF);
      bus_access(OP_READ, {1'b0, SLOT_SCR, 2'b00}, 8'h00);
      bus_access(OP_WRITE, {1'b0, SLOT_IIR, 2'b00}, 8'hAA);
      bus_access(OP_WRITE, {1'b0, SLOT_LSR, 2'b01}, 8'hFF);
      bus_access(OP_WRITE, {1'b0, SLOT_MSR, 2'b10}, 8'h55);
      bus_access(OP_WRITE, {1'b0, SLOT_LCR, 2'b00}, 8'hFF);
      bus_access(OP_WRITE, {1'b0, SLOT_MCR, 2'b00}, 8'hFF);
      bus_access(OP_READ, 8'h20, 8'h00);
      bus_access(OP_WRITE, 8'h7F, 8'hFF);
      bus_access(OP_WRITE, 8'h80, 8'hFF);
      bus_access(OP_READ, 8'hFF, 8'h00);
      send_item(OP_NONE, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF);
      tick(1'b1, 1'b0, 8'h00);
      bus_access(OP_WRITE, {1'b0, SLOT_RBR, 2'b00}, 8'hFF);
      tick(1'b0, 1'b1, 8'hFF);
      tick(1'b1, 1'b1, 8'h00);
      bus_access(OP_READ, {1'b0, SLOT_RBR, 2'b00}, 8'h00);
      bus_access(OP_READ, {1'b0, SLOT_IIR, 2'b00}, 8'h00);
      bus_access(OP_READ, {1'b0, SLOT_LSR, 2'b00}, 8'h00);

      for (int i = 0; i < 550; i++) begin
         if (i == 150) begin
            stall_en <= 1'b1;
            gap_en   <= 1'b1;
         end else if (i == 350) begin
            gap_en   <= 1'b0;
         end else if (i == 450) begin
            stall_en <= 1'b0;
            gap_en   <= 1'b1;
         end
         send_random();
      end
      req_valid <= 1'b0;
      stall_en  <= 1'b0;

      do @(negedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
      @(negedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
